[sv/cpt_pkg.sv]
// Shared types, constants and a helper function of the cache parameter tuner.
`timescale 1ns / 1ps

package cpt_pkg;

  localparam int unsigned CntW      = 20;
  localparam int unsigned RoundW    = 16;
  localparam int unsigned ThrW      = 5;
  localparam int unsigned WinW      = 5;
  localparam int unsigned CandW     = 16;
  localparam int unsigned VotW      = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned TestCache = 1;

  localparam logic [CntW-1:0]  CntMax       = {CntW{1'b1}};
  localparam logic [CandW-1:0] ThrLo        = 16'd6;
  localparam logic [CandW-1:0] ThrHi        = 16'd17;
  localparam logic [CandW-1:0] CountLo      = 16'd1;
  localparam logic [CandW-1:0] CountHi      = 16'd30;

  typedef enum logic {
    ReqAccess = 1'b0,
    ReqStart  = 1'b1
  } cpt_req_e;

  typedef enum logic [1:0] {
    SetThreshold  = 2'd0,
    SetWindow     = 2'd1,
    SetCandidates = 2'd2,
    SetVoters     = 2'd3
  } cpt_setting_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCycleTicks    = 3'd0,
    RegCyclesPerTest = 3'd1,
    RegCacheCapacity = 3'd2,
    RegInitThreshold = 3'd3,
    RegInitWindow    = 3'd4,
    RegInitCands     = 3'd5,
    RegInitVoters    = 3'd6
  } cpt_reg_e;

  typedef struct packed {
    logic [ThrW-1:0]  threshold;
    logic [WinW-1:0]  window;
    logic [CandW-1:0] candidates;
    logic [VotW-1:0]  voters;
  } cpt_settings_t;

  typedef struct packed {
    logic load_init;
    logic count;
    logic clear;
    logic take_new;
  } cpt_lane_ctrl_t;

  typedef struct packed {
    logic             cycle_end;
    logic             best_cache;
    logic             still_evaluating;
    logic [1:0]       tuned_setting;
    cpt_settings_t    settings;
  } cpt_result_t;

  // One step up or down; a result outside [lo, hi] wraps to the opposite end.
  function automatic logic [CandW-1:0] cpt_wrap_step(input logic [CandW-1:0] v,
                                                     input logic up,
                                                     input logic [CandW-1:0] lo,
                                                     input logic [CandW-1:0] hi);
    logic signed [CandW+1:0] n;
    logic [CandW-1:0]        r;
    n = up ? ($signed({2'b00, v}) + 18'sd1) : ($signed({2'b00, v}) - 18'sd1);
    if (n < $signed({2'b00, lo})) begin
      r = hi;
    end else if (n > $signed({2'b00, hi})) begin
      r = lo;
    end else begin
      r = n[CandW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/cpt_if.sv]
// Request and result channel interfaces of the cache parameter tuner.
`timescale 1ns / 1ps

interface cpt_req_if #(
  parameter int unsigned NUM_CACHES = 2
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [NUM_CACHES-1:0] hit_bits;
  logic                  random_up;

  modport source (output valid, output req_type, output hit_bits, output random_up,
                  input ready);
  modport sink   (input valid, input req_type, input hit_bits, input random_up,
                  output ready);
endinterface

interface cpt_res_if;
  logic       valid;
  logic       ready;
  logic       cycle_end;
  logic       best_cache;
  logic       still_evaluating;
  logic [1:0] tuned_setting;
  logic [4:0] test_threshold;
  logic [4:0] test_window;
  logic [15:0] test_candidates;
  logic [4:0] test_voters;

  modport source (output valid, output cycle_end, output best_cache,
                  output still_evaluating, output tuned_setting, output test_threshold,
                  output test_window, output test_candidates, output test_voters,
                  input ready);
  modport sink   (input valid, input cycle_end, input best_cache,
                  input still_evaluating, input tuned_setting, input test_threshold,
                  input test_window, input test_candidates, input test_voters,
                  output ready);
endinterface

[sv/cpt_lane.sv]
// One cache lane: saturating hit counter and the cache's four settings.
`timescale 1ns / 1ps

module cpt_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cpt_pkg::cpt_lane_ctrl_t ctrl_i,
  input  logic                   hit_i,
  input  cpt_pkg::cpt_settings_t init_i,
  input  cpt_pkg::cpt_settings_t new_i,
  output logic [cpt_pkg::CntW-1:0] cnt_o,
  output cpt_pkg::cpt_settings_t set_q_o,
  output cpt_pkg::cpt_settings_t set_d_o
);
  import cpt_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  cpt_settings_t   set_q, set_d;

  // The merge stage sees the count with this beat's hit already added.
  assign cnt_inc = (ctrl_i.count && hit_i && (cnt_q != CntMax)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_d   = ctrl_i.clear ? '0 : cnt_inc;

  always_comb begin
    set_d = set_q;
    if (ctrl_i.load_init) begin
      set_d = init_i;
    end else if (ctrl_i.take_new) begin
      set_d = new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
  end

  assign cnt_o   = cnt_inc;
  assign set_q_o = set_q;
  assign set_d_o = set_d;
endmodule

[sv/cpt_merge.sv]
// Merge stage: picks the cache with the most hits and forms the nudged test settings.
`timescale 1ns / 1ps

module cpt_merge #(
  parameter int unsigned NUM_CACHES = 2,
  localparam int unsigned IdxW = $clog2(NUM_CACHES)
) (
  input  logic [cpt_pkg::CntW-1:0]  cnt_i [NUM_CACHES],
  input  cpt_pkg::cpt_settings_t    set_i [NUM_CACHES],
  input  cpt_pkg::cpt_setting_e     sel_i,
  input  logic                      up_i,
  input  logic [cpt_pkg::CandW-1:0] capacity_i,
  output logic [IdxW-1:0]           best_o,
  output cpt_pkg::cpt_settings_t    win_o,
  output cpt_pkg::cpt_settings_t    nudged_o
);
  import cpt_pkg::*;

  logic [CntW-1:0] max_cnt;
  logic [IdxW-1:0] best;
  cpt_settings_t   win, nudged;

  // Strictly greater keeps the lowest index on a tie.
  always_comb begin
    max_cnt = cnt_i[0];
    best    = '0;
    for (int i = 1; i < NUM_CACHES; i++) begin
      if (cnt_i[i] > max_cnt) begin
        max_cnt = cnt_i[i];
        best    = IdxW'(i);
      end
    end
  end

  assign win = set_i[best];

  always_comb begin
    nudged = win;
    unique case (sel_i)
      SetThreshold: begin
        nudged.threshold = ThrW'(cpt_wrap_step(CandW'(win.threshold), up_i, ThrLo, ThrHi));
      end
      SetWindow: begin
        nudged.window = WinW'(cpt_wrap_step(CandW'(win.window), up_i, CountLo, CountHi));
      end
      SetCandidates: begin
        nudged.candidates = cpt_wrap_step(win.candidates, up_i, CountLo, capacity_i);
      end
      SetVoters: begin
        nudged.voters = VotW'(cpt_wrap_step(CandW'(win.voters), up_i, CountLo, CountHi));
      end
      default: begin
        nudged = win;
      end
    endcase
  end

  assign best_o   = best;
  assign win_o    = win;
  assign nudged_o = nudged;
endmodule

[sv/cache_parameter_tuner_unit.sv]
// Top level of the cache parameter tuner: control counters, lanes, merge and output buffer.
//
//  channel  | dir | handshake     | beat contents
//  ---------+-----+---------------+---------------------------------------------------
//  req_i    | in  | valid / ready | req_type, hit_bits[NUM_CACHES], random_up
//  res_o    | out | valid / ready | cycle_end, best_cache, still_evaluating,
//           |     |               | tuned_setting, test_threshold/window/candidates/voters
//  cfg      | in  | cfg_we_i      | cfg_idx_i selects the register, cfg_data_i the value
//
// Every request beat is finished in the cycle it is accepted, one beat per clock while
// req_i.ready is high; the cycle-closing path runs the lane counters, the hit compare
// across the lanes, the copy of the winning settings and the nudge of the test cache in
// that same cycle. Its result enters the output register, or the skid register while that
// is held, so up to two results wait and req_i.ready falls only when both are full.
// Reset clears the counters and the flags; cache settings stay unknown until a start beat.
`timescale 1ns / 1ps

module cache_parameter_tuner_unit #(
  parameter int unsigned NUM_CACHES = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpt_pkg::CfgDataW-1:0] cfg_data_i,
  cpt_req_if.sink                      req_i,
  cpt_res_if.source                    res_o
);
  import cpt_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_CACHES);

  // Configuration registers.
  logic [CntW-1:0]   cycle_ticks_q;
  logic [RoundW-1:0] cycles_per_test_q;
  logic [CandW-1:0]  capacity_q;
  cpt_settings_t     init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_ticks_q     <= 20'd1000;
      cycles_per_test_q <= 16'd10;
      capacity_q        <= 16'd64;
      init_q.threshold  <= 5'd10;
      init_q.window     <= 5'd10;
      init_q.candidates <= 16'd8;
      init_q.voters     <= 5'd10;
    end else if (cfg_we_i) begin
      unique case (cpt_reg_e'(cfg_idx_i))
        RegCycleTicks:    cycle_ticks_q     <= cfg_data_i[CntW-1:0];
        RegCyclesPerTest: cycles_per_test_q <= cfg_data_i[RoundW-1:0];
        RegCacheCapacity: capacity_q        <= cfg_data_i[CandW-1:0];
        RegInitThreshold: init_q.threshold  <= cfg_data_i[ThrW-1:0];
        RegInitWindow:    init_q.window     <= cfg_data_i[WinW-1:0];
        RegInitCands:     init_q.candidates <= cfg_data_i[CandW-1:0];
        RegInitVoters:    init_q.voters     <= cfg_data_i[VotW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  logic [CntW-1:0]   tick_q, tick_d, tick_inc;
  logic [RoundW-1:0] round_q, round_d, round_inc;
  logic [1:0]        ptr_q, ptr_d, ptr_inc;
  logic              eval_q, eval_d;

  logic accept, is_start, is_access, close, ptr_wrap;

  assign accept    = req_i.valid && req_i.ready;
  assign is_start  = accept && (cpt_req_e'(req_i.req_type) == ReqStart);
  assign is_access = accept && (cpt_req_e'(req_i.req_type) == ReqAccess) && eval_q;

  assign tick_inc  = tick_q + 1'b1;
  assign close     = is_access && (tick_inc >= cycle_ticks_q);
  assign ptr_inc   = ptr_q + 1'b1;
  assign ptr_wrap  = (ptr_q == 2'd3);
  assign round_inc = round_q + 1'b1;

  always_comb begin
    tick_d  = tick_q;
    round_d = round_q;
    ptr_d   = ptr_q;
    eval_d  = eval_q;
    if (is_start) begin
      tick_d  = '0;
      round_d = '0;
      ptr_d   = '0;
      eval_d  = 1'b1;
    end else if (is_access) begin
      tick_d = close ? '0 : tick_inc;
      if (close) begin
        ptr_d = ptr_inc;
        if (ptr_wrap) begin
          round_d = round_inc;
          if (round_inc >= cycles_per_test_q) begin
            eval_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      round_q <= '0;
      ptr_q   <= '0;
      eval_q  <= 1'b0;
    end else begin
      tick_q  <= tick_d;
      round_q <= round_d;
      ptr_q   <= ptr_d;
      eval_q  <= eval_d;
    end
  end

  // Lanes and merge stage.
  logic [CntW-1:0] lane_cnt   [NUM_CACHES];
  cpt_settings_t   lane_set_q [NUM_CACHES];
  cpt_settings_t   lane_set_d [NUM_CACHES];
  logic [IdxW-1:0] best;
  cpt_settings_t   win_set, nudged_set;

  cpt_merge #(
    .NUM_CACHES (NUM_CACHES)
  ) u_merge (
    .cnt_i      (lane_cnt),
    .set_i      (lane_set_q),
    .sel_i      (cpt_setting_e'(ptr_inc)),
    .up_i       (req_i.random_up),
    .capacity_i (capacity_q),
    .best_o     (best),
    .win_o      (win_set),
    .nudged_o   (nudged_set)
  );

  for (genvar i = 0; i < NUM_CACHES; i++) begin : g_lane
    cpt_lane_ctrl_t ctrl;
    cpt_settings_t  new_set;

    // At each cycle close the test cache takes the nudged winner; the others copy the winner.
    assign ctrl.load_init = is_start;
    assign ctrl.count     = is_access;
    assign ctrl.clear     = close;
    assign ctrl.take_new  = close && ((i == TestCache) || (IdxW'(i) != best));
    assign new_set        = (i == TestCache) ? nudged_set : win_set;

    cpt_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .hit_i   (req_i.hit_bits[i]),
      .init_i  (init_q),
      .new_i   (new_set),
      .cnt_o   (lane_cnt[i]),
      .set_q_o (lane_set_q[i]),
      .set_d_o (lane_set_d[i])
    );
  end

  // Result beat of the accepted item.
  cpt_result_t res_new;

  always_comb begin
    res_new.cycle_end        = close;
    res_new.best_cache       = close ? best[0] : 1'b0;
    res_new.still_evaluating = eval_d;
    res_new.tuned_setting    = close ? ptr_inc : 2'd0;
    res_new.settings         = lane_set_d[TestCache];
  end

  // Output register with a skid register behind it.
  cpt_result_t out_q, skid_q;
  logic        out_v_q, skid_v_q;
  logic        out_free;

  assign req_i.ready = !skid_v_q;
  assign out_free    = !out_v_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= accept;
      end
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_new;
      end
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid            = out_v_q;
  assign res_o.cycle_end        = out_q.cycle_end;
  assign res_o.best_cache       = out_q.best_cache;
  assign res_o.still_evaluating = out_q.still_evaluating;
  assign res_o.tuned_setting    = out_q.tuned_setting;
  assign res_o.test_threshold   = out_q.settings.threshold;
  assign res_o.test_window      = out_q.settings.window;
  assign res_o.test_candidates  = out_q.settings.candidates;
  assign res_o.test_voters      = out_q.settings.voters;
endmodule
